// ===== rtl/operand_addressing_mode_classifier_unit_defines.svh =====
// Assertion macros for the operand addressing mode classifier.
// Included by the modules that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef OPERAND_ADDRESSING_MODE_CLASSIFIER_UNIT_DEFINES_SVH
`define OPERAND_ADDRESSING_MODE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define OAMC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define OAMC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/oamc_pkg.sv =====
// Shared types and constants for the operand addressing mode classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package oamc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int ZP_BITS    = 8;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_Y = 8'h59;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] UPPER_HEX_BIAS = 8'h37;
    localparam logic [7:0] LOWER_HEX_BIAS = 8'h57;

    typedef enum logic [2:0] {
        PC_OTHER, PC_HASH, PC_LPAREN, PC_UPPER_A,
        PC_COMMA, PC_RPAREN, PC_UPPER_X, PC_UPPER_Y
    } punct_t;

    typedef enum logic [2:0] {
        P_START, P_ONLY_A, P_WS, P_SIGN, P_ZERO, P_HEXPFX, P_DIG, P_REST
    } phase_t;

    typedef enum logic [1:0] {F_PLAIN, F_IMM, F_IND} form_t;

    typedef enum logic [1:0] {R_DEC, R_OCT, R_HEX} radix_t;

    typedef enum logic [3:0] {
        S_EMPTY, S_C, S_CX, S_CXR, S_CXM, S_CY, S_CBAD, S_R, S_RC, S_RCY, S_OTHER
    } suffix_t;

    typedef enum logic [3:0] {
        MODE_NONE, MODE_ACC, MODE_IMM, MODE_ZP, MODE_ABS,
        MODE_IDX_X, MODE_IDX_Y, MODE_IND, MODE_IDX_IND, MODE_IND_IDX
    } mode_t;

    // One classified character as it travels from front to back
    typedef struct packed {
        logic       chr;
        logic       last;
        punct_t     punct;
        logic       space;
        logic       sign;
        logic       minus;
        logic       zero;
        logic       nzdec;
        logic       xch;
        logic [3:0] digit;
        logic       dhex;
        logic       ddec;
        logic       doct;
    } tok_t;

    // Token state captured at its last character
    typedef struct packed {
        phase_t  phase;
        form_t   form;
        logic    negative;
        logic    overflowed;
        logic    digits_seen;
        suffix_t suffix;
    } fin_t;

endpackage

// ===== rtl/oamc_front.sv =====
// Front end: classifies each character and tracks NUL termination of the token.
// Depends on oamc_pkg.
`timescale 1ns / 1ps

module oamc_front import oamc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_has_char,
    input  logic       s_last,
    output logic       push_valid,
    input  logic       push_ready,
    output tok_t       push_data
);

    logic term_reg;
    logic term_next;
    logic accept;
    logic [7:0] ulet;
    logic [7:0] llet;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;
    assign ulet       = s_ch - UPPER_HEX_BIAS;
    assign llet       = s_ch - LOWER_HEX_BIAS;

    always_comb begin
        push_data       = '0;
        push_data.chr   = s_has_char && !term_reg && (s_ch != CH_NUL);
        push_data.last  = s_last;
        case (s_ch)
            CH_HASH:    push_data.punct = PC_HASH;
            CH_LPAREN:  push_data.punct = PC_LPAREN;
            CH_UPPER_A: push_data.punct = PC_UPPER_A;
            CH_COMMA:   push_data.punct = PC_COMMA;
            CH_RPAREN:  push_data.punct = PC_RPAREN;
            CH_UPPER_X: push_data.punct = PC_UPPER_X;
            CH_UPPER_Y: push_data.punct = PC_UPPER_Y;
            default:    push_data.punct = PC_OTHER;
        endcase
        push_data.space = s_ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        push_data.sign  = (s_ch == CH_PLUS) || (s_ch == CH_MINUS);
        push_data.minus = (s_ch == CH_MINUS);
        push_data.zero  = (s_ch == CH_ZERO);
        push_data.nzdec = s_ch inside {[CH_ONE:CH_NINE]};
        push_data.xch   = (s_ch == CH_LOWER_X) || (s_ch == CH_UPPER_X);
        push_data.doct  = s_ch inside {[CH_ZERO:CH_SEVEN]};
        push_data.ddec  = s_ch inside {[CH_ZERO:CH_NINE]};
        if (s_ch inside {[CH_ZERO:CH_NINE]}) begin
            push_data.digit = s_ch[3:0];
            push_data.dhex  = 1'b1;
        end else if (s_ch inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            push_data.digit = ulet[3:0];
            push_data.dhex  = 1'b1;
        end else if (s_ch inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            push_data.digit = llet[3:0];
            push_data.dhex  = 1'b1;
        end
    end

    // A NUL ends the token; ignore characters until the last transfer
    always_comb begin
        term_next = term_reg;
        if (accept) begin
            if (s_last) begin
                term_next = 1'b0;
            end else if (s_has_char && s_ch == CH_NUL) begin
                term_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= 1'b0;
        end else begin
            term_reg <= term_next;
        end
    end

endmodule

// ===== rtl/oamc_queue.sv =====
// Short queue of classified characters between front and back.
// Depends on oamc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "operand_addressing_mode_classifier_unit_defines.svh"

module oamc_queue import oamc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  tok_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output tok_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `OAMC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count past depth")
    `OAMC_ASSERT_NEXT(a_head_kept, pop_valid && !pop_ready, pop_data == $past(pop_data), "queue head changed while stalled")

endmodule

// ===== rtl/oamc_exec.sv =====
// Back end: per-character parse state machine and shift-add accumulator.
// Depends on oamc_pkg; hands the final token state to the result stage.
`timescale 1ns / 1ps

module oamc_exec import oamc_pkg::*; #(
    parameter int ACC_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tok_t                pop_data,
    output logic                fin_valid,
    input  logic                fin_ready,
    output fin_t                fin_data,
    output logic [ACC_BITS-1:0] fin_acc
);

    phase_t              phase_reg, phase_next, phase_step, num_phase;
    form_t               form_reg, form_next, form_step;
    radix_t              radix_reg, radix_next, radix_step;
    suffix_t             suffix_reg, suffix_next, suffix_step, suffix_fin;
    logic                neg_reg, neg_next, neg_step;
    logic                ovf_reg, ovf_next, ovf_step;
    logic                dig_reg, dig_next, dig_step;
    logic                ws_reg, ws_next, ws_step;
    logic [ACC_BITS-1:0] acc_reg, acc_next, acc_step, acc_first;
    logic                fin_valid_reg, fin_valid_next;
    fin_t                fin_reg;
    logic [ACC_BITS-1:0] fin_acc_reg;
    logic [ACC_BITS+3:0] scaled, wide;
    logic                take, chr, in_radix, wide_ovf;
    logic                lead_hash, lead_paren, lead_a, lead_any, fin_load;
    tok_t                t;

    function automatic suffix_t feed_rest(suffix_t s, punct_t p);
        suffix_t r;
        r = s;
        case (s)
            S_EMPTY: r = (p == PC_COMMA) ? S_C : (p == PC_RPAREN) ? S_R : S_OTHER;
            S_C:     r = (p == PC_UPPER_X) ? S_CX : (p == PC_UPPER_Y) ? S_CY : S_CBAD;
            S_CX:    r = (p == PC_RPAREN) ? S_CXR : S_CXM;
            S_CXR:   r = S_CXM;
            S_R:     r = (p == PC_COMMA) ? S_RC : S_OTHER;
            S_RC:    r = (p == PC_UPPER_Y) ? S_RCY : S_OTHER;
            S_RCY:   r = S_OTHER;
            default: r = s;
        endcase
        return r;
    endfunction

    assign t          = pop_data;
    assign pop_ready  = !(t.last && fin_valid_reg && !fin_ready);
    assign take       = pop_valid && pop_ready;
    assign chr        = take && t.chr;
    assign fin_load   = take && t.last;
    assign num_phase  = (phase_reg == P_START) ? P_WS : phase_reg;
    assign lead_hash  = (phase_reg == P_START) && (t.punct == PC_HASH);
    assign lead_paren = (phase_reg == P_START) && (t.punct == PC_LPAREN);
    assign lead_a     = (phase_reg == P_START) && (t.punct == PC_UPPER_A);
    assign lead_any   = lead_hash || lead_paren || lead_a;
    assign acc_first  = {{(ACC_BITS-4){1'b0}}, t.digit};

    always_comb begin
        case (radix_reg)
            R_OCT:   in_radix = t.doct;
            R_HEX:   in_radix = t.dhex;
            default: in_radix = t.ddec;
        endcase
    end

    // acc * radix + digit, exact; any bit above the accumulator means overflow
    always_comb begin
        case (radix_reg)
            R_OCT:   scaled = {1'b0, acc_reg, 3'b000};
            R_HEX:   scaled = {acc_reg, 4'b0000};
            default: scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        endcase
        wide     = scaled + {{ACC_BITS{1'b0}}, t.digit};
        wide_ovf = |wide[ACC_BITS+3:ACC_BITS];
    end

    // Phase: next state
    always_comb begin
        phase_step = phase_reg;
        if (chr) begin
            if (lead_hash || lead_paren) begin
                phase_step = P_WS;
            end else if (lead_a) begin
                phase_step = P_ONLY_A;
            end else if (phase_reg == P_ONLY_A) begin
                phase_step = P_REST;
            end else begin
                case (num_phase)
                    P_WS: begin
                        if (t.space)      phase_step = P_WS;
                        else if (t.sign)  phase_step = P_SIGN;
                        else if (t.zero)  phase_step = P_ZERO;
                        else if (t.nzdec) phase_step = P_DIG;
                        else              phase_step = P_REST;
                    end
                    P_SIGN: begin
                        if (t.zero)       phase_step = P_ZERO;
                        else if (t.nzdec) phase_step = P_DIG;
                        else              phase_step = P_REST;
                    end
                    P_ZERO: begin
                        if (t.xch)        phase_step = P_HEXPFX;
                        else if (t.doct)  phase_step = P_DIG;
                        else              phase_step = P_REST;
                    end
                    P_HEXPFX: phase_step = t.dhex ? P_DIG : P_REST;
                    P_DIG:    phase_step = in_radix ? P_DIG : P_REST;
                    default:  phase_step = P_REST;
                endcase
            end
        end
        phase_next = fin_load ? P_START : phase_step;
    end

    // Token state and accumulator
    always_comb begin
        form_step   = form_reg;
        radix_step  = radix_reg;
        suffix_step = suffix_reg;
        neg_step    = neg_reg;
        ovf_step    = ovf_reg;
        dig_step    = dig_reg;
        ws_step     = ws_reg;
        acc_step    = acc_reg;
        if (chr) begin
            if (phase_reg == P_START) begin
                form_step = lead_hash ? F_IMM : lead_paren ? F_IND : F_PLAIN;
            end
            if (!lead_any) begin
                if (phase_reg == P_ONLY_A) begin
                    suffix_step = S_OTHER;
                end else begin
                    case (num_phase)
                        P_WS: begin
                            if (t.space) begin
                                ws_step = 1'b1;
                            end else if (t.sign) begin
                                neg_step = t.minus;
                            end else if (t.zero) begin
                                dig_step = 1'b1;
                            end else if (t.nzdec) begin
                                dig_step   = 1'b1;
                                radix_step = R_DEC;
                                acc_step   = acc_first;
                            end else begin
                                suffix_step = ws_reg ? S_OTHER : feed_rest(suffix_reg, t.punct);
                            end
                        end
                        P_SIGN: begin
                            if (t.zero) begin
                                dig_step = 1'b1;
                            end else if (t.nzdec) begin
                                dig_step   = 1'b1;
                                radix_step = R_DEC;
                                acc_step   = acc_first;
                            end else begin
                                suffix_step = S_OTHER;
                            end
                        end
                        P_ZERO: begin
                            if (t.doct) begin
                                radix_step = R_OCT;
                                acc_step   = acc_first;
                            end else if (!t.xch) begin
                                suffix_step = feed_rest(suffix_reg, t.punct);
                            end
                        end
                        P_HEXPFX: begin
                            if (t.dhex) begin
                                radix_step = R_HEX;
                                acc_step   = acc_first;
                            end else begin
                                suffix_step = S_OTHER;
                            end
                        end
                        P_DIG: begin
                            if (!in_radix) begin
                                suffix_step = feed_rest(suffix_reg, t.punct);
                            end else if (!ovf_reg) begin
                                // saturate: keep consuming digits, stop accumulating
                                if (wide_ovf) ovf_step = 1'b1;
                                else          acc_step = wide[ACC_BITS-1:0];
                            end
                        end
                        default: suffix_step = feed_rest(suffix_reg, t.punct);
                    endcase
                end
            end
        end

        // Unfinished number at the end leaves an unusable remainder
        if ((phase_step == P_WS && ws_step) || phase_step == P_SIGN || phase_step == P_HEXPFX) begin
            suffix_fin = S_OTHER;
        end else begin
            suffix_fin = suffix_step;
        end

        if (fin_load) begin
            form_next   = F_PLAIN;
            radix_next  = R_DEC;
            suffix_next = S_EMPTY;
            neg_next    = 1'b0;
            ovf_next    = 1'b0;
            dig_next    = 1'b0;
            ws_next     = 1'b0;
            acc_next    = '0;
        end else begin
            form_next   = form_step;
            radix_next  = radix_step;
            suffix_next = suffix_step;
            neg_next    = neg_step;
            ovf_next    = ovf_step;
            dig_next    = dig_step;
            ws_next     = ws_step;
            acc_next    = acc_step;
        end

        if (fin_load)       fin_valid_next = 1'b1;
        else if (fin_ready) fin_valid_next = 1'b0;
        else                fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= P_START;
            form_reg      <= F_PLAIN;
            radix_reg     <= R_DEC;
            suffix_reg    <= S_EMPTY;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            dig_reg       <= 1'b0;
            ws_reg        <= 1'b0;
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            form_reg      <= form_next;
            radix_reg     <= radix_next;
            suffix_reg    <= suffix_next;
            neg_reg       <= neg_next;
            ovf_reg       <= ovf_next;
            dig_reg       <= dig_next;
            ws_reg        <= ws_next;
            acc_reg       <= acc_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg.phase       <= phase_step;
            fin_reg.form        <= form_step;
            fin_reg.negative    <= neg_step;
            fin_reg.overflowed  <= ovf_step;
            fin_reg.digits_seen <= dig_step;
            fin_reg.suffix      <= suffix_fin;
            fin_acc_reg         <= acc_step;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_data  = fin_reg;
    assign fin_acc   = fin_acc_reg;

endmodule

// ===== rtl/oamc_finish.sv =====
// Result stage: maps the final token state to mode, value and ok; holds the output register.
// Depends on oamc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "operand_addressing_mode_classifier_unit_defines.svh"

module oamc_finish import oamc_pkg::*; #(
    parameter int ACC_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fin_valid,
    output logic                  fin_ready,
    input  fin_t                  fin_data,
    input  logic [ACC_BITS-1:0]   fin_acc,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_mode,
    output logic [VALUE_BITS-1:0] m_value,
    output logic                  m_ok
);

    logic [ACC_BITS-1:0]   val_full;
    logic                  zp, keep, ok;
    mode_t                 mode;
    logic                  m_valid_reg, m_valid_next;
    mode_t                 m_mode_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic                  m_ok_reg;
    logic                  load;

    assign fin_ready = !m_valid_reg || m_ready;
    assign load      = fin_valid && fin_ready;

    always_comb begin
        if (!fin_data.digits_seen)     val_full = '0;
        else if (fin_data.overflowed)  val_full = '1;
        else if (fin_data.negative)    val_full = -fin_acc;
        else                           val_full = fin_acc;
        zp = (val_full[ACC_BITS-1:ZP_BITS] == '0);
    end

    always_comb begin
        mode = MODE_NONE;
        ok   = 1'b1;
        keep = 1'b1;
        if (fin_data.phase == P_START) begin
            keep = 1'b0;
        end else if (fin_data.phase == P_ONLY_A) begin
            mode = MODE_ACC;
            keep = 1'b0;
        end else if (fin_data.form == F_IMM) begin
            mode = MODE_IMM;
        end else if (fin_data.form == F_IND) begin
            case (fin_data.suffix)
                S_R:     mode = MODE_IND;
                S_CXR:   mode = MODE_IDX_IND;
                S_RCY:   mode = MODE_IND_IDX;
                default: ok   = 1'b0;
            endcase
        end else begin
            case (fin_data.suffix)
                S_EMPTY:             mode = zp ? MODE_ZP : MODE_ABS;
                S_CX, S_CXR, S_CXM:  mode = MODE_IDX_X;
                S_CY:                mode = MODE_IDX_Y;
                S_C, S_CBAD:         ok   = 1'b0;
                default:             keep = 1'b0;
            endcase
        end
        if (!ok) begin
            mode = MODE_NONE;
            keep = 1'b0;
        end
    end

    always_comb begin
        if (load)         m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_mode_reg  <= mode;
            m_value_reg <= keep ? val_full[VALUE_BITS-1:0] : '0;
            m_ok_reg    <= ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_mode  = m_mode_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

    `OAMC_ASSERT_NOW(a_bad_is_blank, m_valid_reg && !m_ok_reg, m_mode_reg == MODE_NONE && m_value_reg == '0, "malformed result carries mode or value")
    `OAMC_ASSERT_NOW(a_zp_is_byte, m_valid_reg && m_mode_reg == MODE_ZP, m_value_reg[VALUE_BITS-1:ZP_BITS] == '0, "zero page result above one byte")

endmodule

// ===== rtl/operand_addressing_mode_classifier_unit.sv =====
// After its last character, a token's result is registered in the back end, then on m_.
// Throughput: one character per cycle unless stalled, set by the combinational shift-add.
// The character queue lets the front keep taking characters while a result waits.
// Reset: aresetn synchronous, active low; clears the parse state, queue and output valid.
// Every result returns the parse state to the start of a token.
`timescale 1ns / 1ps

module operand_addressing_mode_classifier_unit import oamc_pkg::*; #(
    parameter int ACC_BITS    = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_has_char,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_mode,
    output logic [15:0] m_value,
    output logic        m_ok
);

    logic                push_valid, push_ready;
    tok_t                push_data;
    logic                pop_valid, pop_ready;
    tok_t                pop_data;
    logic                fin_valid, fin_ready;
    fin_t                fin_data;
    logic [ACC_BITS-1:0] fin_acc;

    oamc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .s_has_char (s_has_char),
        .s_last     (s_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    oamc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    oamc_exec #(.ACC_BITS(ACC_BITS)) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data),
        .fin_acc   (fin_acc)
    );

    oamc_finish #(.ACC_BITS(ACC_BITS)) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data),
        .fin_acc   (fin_acc),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mode    (m_mode),
        .m_value   (m_value),
        .m_ok      (m_ok)
    );

endmodule
